// File: hw/rtl/pidaw_pkg.sv
// Shared types, register indexes and constants for the anti-windup PID controller.
package pidaw_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_OUTPUT_LOW  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_OUTPUT_HIGH = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_INTEG_LOW   = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_INTEG_HIGH  = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_MIN_STEP    = 3'd7;

    // Filter coefficients 0.7 and 0.3 in signed Q1.16
    localparam logic signed [16:0] COEF_OLD = 17'sd45875;
    localparam logic signed [16:0] COEF_NEW = 17'sd19661;

    localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32 = 32'sh80000000;

    // Divider request from the sequencer
    typedef struct packed {
        logic               start;
        logic signed [32:0] num;
        logic        [30:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } t_div_rsp;

    // Saturate a 66-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7fffffff) begin
            r = MAX32;
        end else if (v < -66'sh0_80000000) begin
            r = MIN32;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Raise to low, then lower to high
    function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        logic signed [31:0] r;
        r = v;
        if (r < lo) begin
            r = lo;
        end
        if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/pidaw_div.sv
// Restoring divider: 33-bit magnitude numerator scaled by 2^16, by 31-bit divisor, one bit a cycle.
module pidaw_div
    import pidaw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [47:0] r_q;
    logic [31:0] r_rem;
    logic [30:0] r_den;
    logic        r_neg;
    logic        r_done;

    logic [32:0] w_num_mag;
    logic [31:0] w_shift;
    logic [32:0] w_diff;

    assign w_num_mag = i_req.num[32] ? 33'(-i_req.num) : 33'(i_req.num);
    assign w_shift   = {r_rem[30:0], r_q[47]};
    assign w_diff    = {1'b0, w_shift} - {2'b00, r_den};

    // Shift in one numerator bit and subtract when it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd47;
                r_q    <= {w_num_mag[31:0], 16'h0000};
                r_rem  <= {31'd0, w_num_mag[32]};
                r_den  <= i_req.den;
                r_neg  <= i_req.num[32];
            end else if (r_busy) begin
                r_q <= {r_q[46:0], ~w_diff[32]};
                if (!w_diff[32]) begin
                    r_rem <= w_diff[31:0];
                end else begin
                    r_rem <= w_shift;
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restore sign, then saturate to 32 bits
    logic signed [49:0] w_sq;
    assign w_sq = r_neg ? -$signed({2'b00, r_q}) : $signed({2'b00, r_q});
    assign o_rsp.done = r_done;
    assign o_rsp.quot = sat32(66'(w_sq));

endmodule

// File: hw/rtl/pidaw_mul.sv
// Registered signed 33x33 multiplier shared by every product step.
module pidaw_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);

    // Hold one product per cycle
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule

// File: hw/rtl/pid_controller_antiwindup.sv
// Top level of the PID controller with integral clamp and filtered derivative.
// With the derivative path, the 48-step bit-serial divider for error change over
// step_time dominates the time to a result; products run one at a time through a
// single registered 33x33 multiplier. The block takes the next item once the result
// register has been transferred out.
module pid_controller_antiwindup
    import pidaw_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CfgIdxW-1:0]         i_cfg_index,
    input  logic [31:0]                i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [31:0]         i_setpoint,
    input  logic signed [31:0]         i_measurement,
    input  logic [30:0]                i_step_time,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [31:0]         o_control_out
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PMUL  = 4'd1;
    localparam logic [3:0] S_IMUL1 = 4'd2;
    localparam logic [3:0] S_IMUL2 = 4'd3;
    localparam logic [3:0] S_IACC  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_FOLD  = 4'd6;
    localparam logic [3:0] S_FNEW  = 4'd7;
    localparam logic [3:0] S_DMUL  = 4'd8;
    localparam logic [3:0] S_SUM   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic signed [31:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic signed [31:0] r_output_low, r_output_high, r_integ_low, r_integ_high;
    logic [30:0]        r_min_step;

    logic signed [31:0] r_integ, r_last_err, r_filt;
    logic               r_first;

    logic [3:0]         r_state;
    logic               r_wait;
    logic signed [31:0] r_err, r_pterm, r_dterm, r_tmp;
    logic signed [65:0] r_facc;
    logic [30:0]        r_dt;
    logic               r_dpath;
    logic               r_ovalid;
    logic signed [31:0] r_out;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_p;
    t_div_req           w_dreq;
    t_div_rsp           w_drsp;
    logic signed [32:0] w_diff;
    logic signed [31:0] w_mulq;

    pidaw_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_p));
    pidaw_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // Floor by 2^16 is an arithmetic shift
    assign w_mulq = sat32(w_p >>> 16);
    assign w_diff = 33'(r_err) - 33'(r_last_err);

    assign w_dreq.start = (r_state == S_DIV) && !r_wait;
    assign w_dreq.num   = w_diff;
    assign w_dreq.den   = r_dt;

    // Route operands to the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_PMUL:  begin w_ma = 33'(r_prop_gain);  w_mb = 33'(r_err); end
            S_IMUL1: begin w_ma = 33'(r_integ_gain); w_mb = 33'(r_err); end
            S_IMUL2: begin w_ma = 33'(r_tmp);        w_mb = $signed({2'b00, r_dt}); end
            S_FOLD:  begin w_ma = 33'(COEF_OLD);     w_mb = 33'(r_filt); end
            S_FNEW:  begin w_ma = 33'(COEF_NEW);     w_mb = 33'(r_tmp); end
            S_DMUL:  begin w_ma = 33'(r_deriv_gain); w_mb = 33'(r_filt); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign o_stall       = (r_state != S_IDLE) || r_ovalid;
    assign o_valid       = r_ovalid;
    assign o_control_out = r_out;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
            r_deriv_gain  <= '0;
            r_output_low  <= -32'sd65536;
            r_output_high <= 32'sd65536;
            r_integ_low   <= -32'sd65536;
            r_integ_high  <= 32'sd65536;
            r_min_step    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data;
                CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data;
                CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data;
                CFG_OUTPUT_LOW:  r_output_low  <= i_cfg_data;
                CFG_OUTPUT_HIGH: r_output_high <= i_cfg_data;
                CFG_INTEG_LOW:   r_integ_low   <= i_cfg_data;
                CFG_INTEG_HIGH:  r_integ_high  <= i_cfg_data;
                CFG_MIN_STEP:    r_min_step    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Sequence one item through the shared units
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wait     <= 1'b0;
            r_ovalid   <= 1'b0;
            r_integ    <= '0;
            r_last_err <= '0;
            r_filt     <= '0;
            r_first    <= 1'b1;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_err   <= sat32(66'(i_setpoint) - 66'(i_measurement));
                        r_dt    <= i_step_time;
                        r_dpath <= !r_first && (i_step_time > r_min_step);
                        r_wait  <= 1'b0;
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL, S_IMUL1, S_IMUL2, S_FOLD, S_FNEW, S_DMUL: begin
                    // Issue the operands, then collect the registered product
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else begin
                        r_wait <= 1'b0;
                        case (r_state)
                            S_PMUL:  begin r_pterm <= w_mulq; r_state <= S_IMUL1; end
                            S_IMUL1: begin r_tmp <= w_mulq;   r_state <= S_IMUL2; end
                            S_IMUL2: begin r_tmp <= w_mulq;   r_state <= S_IACC;  end
                            S_FOLD:  begin r_facc <= w_p;     r_state <= S_FNEW;  end
                            S_FNEW: begin
                                r_filt  <= sat32((r_facc + w_p) >>> 16);
                                r_state <= S_DMUL;
                            end
                            default: begin r_dterm <= w_mulq; r_state <= S_SUM; end
                        endcase
                    end
                end
                S_IACC: begin
                    r_integ <= clamp32(sat32(66'(r_integ) + 66'(r_tmp)),
                                       r_integ_low, r_integ_high);
                    r_dterm <= '0;
                    r_state <= r_dpath ? S_DIV : S_SUM;
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        r_tmp   <= w_drsp.quot;
                        r_wait  <= 1'b0;
                        r_state <= S_FOLD;
                    end else begin
                        r_wait  <= 1'b1;
                    end
                end
                S_SUM: begin
                    r_tmp   <= clamp32(sat32(66'(r_pterm) + 66'(r_integ) + 66'(r_dterm)),
                                       r_output_low, r_output_high);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_out      <= r_tmp;
                    r_ovalid   <= 1'b1;
                    r_last_err <= r_err;
                    r_first    <= 1'b0;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
